// File: rtl/acmrs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the air-conditioning mode and ramp step block.
// Depends on nothing; imported by every module of the block.
package acmrs_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned TEMP_W      = 16;
	localparam int unsigned POS_W       = 13;
	localparam int unsigned TSTEP_W     = 12;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TEMP_STEP    = 3'd0,
		REG_POS_STEP     = 3'd1,
		REG_PRESSURE_MIN = 3'd2,
		REG_VOLTAGE_MIN  = 3'd3
	} cfg_reg_e;

	localparam logic [TSTEP_W-1:0] TEMP_STEP_RST    = 12'd77;
	localparam logic [POS_W-1:0]   POS_STEP_RST     = 13'd82;
	localparam logic [15:0]        PRESSURE_MIN_RST = 16'd307;
	localparam logic [15:0]        VOLTAGE_MIN_RST  = 16'd4608;

	localparam logic signed [TEMP_W-1:0] T_DUCT_NORMAL = 16'sd10240;
	localparam logic signed [TEMP_W-1:0] T_DUCT_FAULT  = 16'sd14080;
	localparam logic signed [TEMP_W-1:0] T_UNIT_FAULT  = 16'sd5376;
	localparam logic signed [TEMP_W-1:0] T_UNIT_NORMAL = 16'sd1280;
	localparam logic signed [TEMP_W:0]   SNAP_BAND     = 17'sd51;
	localparam logic [POS_W-1:0]         POS_LOW       = 13'd205;
	localparam logic [POS_W-1:0]         POS_HIGH      = 13'd3892;
	localparam logic [POS_W-1:0]         POS_FULL      = 13'd4096;

	typedef struct packed {
		logic [TSTEP_W-1:0] temp_step;
		logic [POS_W-1:0]   pos_step;
		logic [15:0]        pressure_min;
		logic [15:0]        voltage_min;
	} cfg_t;

	typedef struct packed {
		logic               power_on;
		logic               supply_ok;
		logic [15:0]        supply_pressure;
		logic               unit_fault;
		logic               relay_three;
		logic               relay_two;
		logic [15:0]        bus_voltage;
		logic signed [15:0] outside_temp;
	} item_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] duct_temp;
		logic signed [TEMP_W-1:0] unit_temp;
		logic signed [TEMP_W-1:0] unit_target;
		logic [POS_W-1:0]         valve13_pos;
		logic [POS_W-1:0]         valve14_pos;
	} state_t;

	typedef struct packed {
		logic valve14;
		logic lamp;
		logic faultmode;
		logic running;
		logic relay4;
		logic relay1;
		logic valve11;
		logic cutoff;
		logic shutoff;
	} status_t;

endpackage

// File: rtl/acmrs_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: step sizes and thresholds.
// Depends on acmrs_pkg.
module acmrs_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [acmrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [acmrs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output acmrs_pkg::cfg_t                      cfg
);
	import acmrs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.temp_step    <= TEMP_STEP_RST;
			cfg_q.pos_step     <= POS_STEP_RST;
			cfg_q.pressure_min <= PRESSURE_MIN_RST;
			cfg_q.voltage_min  <= VOLTAGE_MIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEMP_STEP:    cfg_q.temp_step    <= cfg_data[TSTEP_W-1:0];
				REG_POS_STEP:     cfg_q.pos_step     <= cfg_data[POS_W-1:0];
				REG_PRESSURE_MIN: cfg_q.pressure_min <= cfg_data;
				REG_VOLTAGE_MIN:  cfg_q.voltage_min  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/acmrs_step.sv
`timescale 1ns / 1ps
// Next-state logic for one tick: mode select, temperature ramps, valve slews, flags.
// Depends on acmrs_pkg.
module acmrs_step (
	input  acmrs_pkg::cfg_t    cfg,
	input  acmrs_pkg::item_t   item,
	input  acmrs_pkg::state_t  cur,
	output acmrs_pkg::state_t  nxt,
	output acmrs_pkg::status_t status
);
	import acmrs_pkg::*;

	function automatic logic signed [TEMP_W-1:0] sat_step(
		input logic signed [TEMP_W-1:0] t,
		input logic [TSTEP_W-1:0]       k,
		input logic                     dn
	);
		logic signed [TEMP_W+1:0] c;
		logic signed [TEMP_W+1:0] s;
		logic signed [TEMP_W+1:0] ks;
		c  = (TEMP_W+2)'(t);
		ks = $signed({{(TEMP_W+2-TSTEP_W){1'b0}}, k});
		s  = dn ? c - ks : c + ks;
		if (s > 18'sd32767)
			return 16'sh7fff;
		else if (s < -18'sd32768)
			return 16'sh8000;
		else
			return s[TEMP_W-1:0];
	endfunction

	function automatic logic signed [TEMP_W-1:0] ramp(
		input logic signed [TEMP_W-1:0] t,
		input logic signed [TEMP_W-1:0] target,
		input logic [TSTEP_W-1:0]       k
	);
		logic signed [TEMP_W:0] d;
		d = (TEMP_W+1)'(t) - (TEMP_W+1)'(target);
		if (d > SNAP_BAND)
			return sat_step(t, k, 1'b1);
		else if (d < -SNAP_BAND)
			return sat_step(t, k, 1'b0);
		else
			return target;
	endfunction

	function automatic logic [POS_W-1:0] pos_down(
		input logic [POS_W-1:0] p,
		input logic [POS_W-1:0] k
	);
		logic signed [POS_W+1:0] v;
		v = $signed({2'b00, p}) - $signed({2'b00, k});
		if (p < POS_LOW || v < 0)
			return '0;
		else
			return v[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] pos_up(
		input logic [POS_W-1:0] p,
		input logic [POS_W-1:0] k
	);
		logic [POS_W:0] v;
		v = {1'b0, p} + {1'b0, k};
		if (p >= POS_HIGH || v > {1'b0, POS_FULL})
			return POS_FULL;
		else
			return v[POS_W-1:0];
	endfunction

	logic signed [TEMP_W:0]   d_unit;
	logic signed [TEMP_W-1:0] duct_target;
	logic                     lost;

	always_comb begin
		nxt         = cur;
		status      = '0;
		duct_target = T_DUCT_NORMAL;
		d_unit      = (TEMP_W+1)'(cur.unit_temp) - (TEMP_W+1)'(T_UNIT_NORMAL);
		lost        = !item.supply_ok || (item.supply_pressure < cfg.pressure_min);

		if (item.power_on) begin
			if (lost) begin
				status.shutoff  = 1'b1;
				status.relay1   = 1'b1;
				duct_target     = item.outside_temp;
				nxt.valve13_pos = pos_down(cur.valve13_pos, cfg.pos_step);
			end else if (item.unit_fault) begin
				status.faultmode = 1'b1;
				status.relay1    = 1'b1;
				status.cutoff    = 1'b1;
				status.relay4    = 1'b1;
				nxt.unit_target  = T_UNIT_FAULT;
				duct_target      = T_DUCT_FAULT;
			end else begin
				status.valve11  = 1'b1;
				status.running  = 1'b1;
				nxt.unit_target = T_UNIT_NORMAL;
				if (d_unit > SNAP_BAND) begin
					nxt.valve13_pos = pos_down(cur.valve13_pos, cfg.pos_step);
					nxt.unit_temp   = sat_step(cur.unit_temp, cfg.temp_step, 1'b1);
				end else if (d_unit < -SNAP_BAND) begin
					nxt.valve13_pos = pos_up(cur.valve13_pos, cfg.pos_step);
					nxt.unit_temp   = sat_step(cur.unit_temp, cfg.temp_step, 1'b0);
				end else begin
					nxt.unit_temp = T_UNIT_NORMAL;
				end
			end
			nxt.duct_temp = ramp(cur.duct_temp, duct_target, cfg.temp_step);
			status.lamp   = item.relay_three && status.relay4;
		end else begin
			nxt.duct_temp = '0;
		end

		status.valve14 = status.relay1 ^ item.relay_two;

		if (item.bus_voltage >= cfg.voltage_min) begin
			if (status.valve14)
				nxt.valve14_pos = pos_up(cur.valve14_pos, cfg.pos_step);
			else
				nxt.valve14_pos = pos_down(cur.valve14_pos, cfg.pos_step);
		end
	end

endmodule

// File: rtl/air_conditioning_mode_ramp_step.sv
`timescale 1ns / 1ps
// Air-conditioning mode and ramp step, top level: one simulation tick per transfer.
// Depends on acmrs_pkg, acmrs_cfg and acmrs_step.
//
// Takes one tick per clock cycle while in_stall is low. A tick is captured in an input
// register, stepped against the held temperatures and valve positions, and its
// result is written into the output register, which drives out_valid. The stored
// state is updated in the same cycle as the output register, so a tick following
// directly behind sees the previous tick's result. in_stall rises only when the
// input register is full and a finished result is still held by out_stall.
// Configuration writes take effect at the next edge and must be made while no
// tick is in flight.
module air_conditioning_mode_ramp_step (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [acmrs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [acmrs_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              power_on,
	input  logic                              supply_ok,
	input  logic [15:0]                       supply_pressure,
	input  logic                              unit_fault,
	input  logic                              relay_three,
	input  logic                              relay_two,
	input  logic [15:0]                       bus_voltage,
	input  logic signed [15:0]                outside_temp,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [8:0]                        status_bits,
	output logic signed [15:0]                duct_temp,
	output logic signed [15:0]                unit_temp,
	output logic signed [15:0]                unit_target,
	output logic [12:0]                       valve13_pos,
	output logic [12:0]                       valve14_pos
);
	import acmrs_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_nxt;
	status_t status_nxt;
	status_t status_s2;
	state_t  result_s2;
	logic    valid_s2;
	logic    advance;
	logic    in_xfer;

	acmrs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	acmrs_step u_step (
		.cfg    (cfg),
		.item   (item_s1),
		.cur    (state_q),
		.nxt    (state_nxt),
		.status (status_nxt)
	);

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.power_on        <= power_on;
			item_s1.supply_ok       <= supply_ok;
			item_s1.supply_pressure <= supply_pressure;
			item_s1.unit_fault      <= unit_fault;
			item_s1.relay_three     <= relay_three;
			item_s1.relay_two       <= relay_two;
			item_s1.bus_voltage     <= bus_voltage;
			item_s1.outside_temp    <= outside_temp;
		end
	end

	// held state, advance once per stepped tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			result_s2 <= state_nxt;
			status_s2 <= status_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign status_bits = status_s2;
	assign duct_temp   = result_s2.duct_temp;
	assign unit_temp   = result_s2.unit_temp;
	assign unit_target = result_s2.unit_target;
	assign valve13_pos = result_s2.valve13_pos;
	assign valve14_pos = result_s2.valve14_pos;

endmodule
